[sv/rwcp_pkg.sv]
// Shared types and constants for the RIFF/WAVE chunk parser.
package rwcp_pkg;

  // Four-character codes as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_FORMAT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_DATA      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FORMAT_LEN = 2'd2;

  localparam logic [7:0] MIN_FORMAT_RESET = 8'd14;

  // Header byte counts at which a word is complete
  localparam logic [3:0] HDR_WORD0 = 4'd4;
  localparam logic [3:0] HDR_WORD1 = 4'd8;
  localparam logic [3:0] HDR_WORD2 = 4'd12;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_WAVE  = 3'd1,
    ST_NOT_RIFF  = 3'd2,
    ST_FMT_SHORT = 3'd3,
    ST_END       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_CHUNK = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

endpackage

[sv/rwcp_ifs.sv]
// Channel interfaces of the RIFF/WAVE chunk parser: byte input, result output, configuration.
interface rwcp_byte_if
  import rwcp_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface rwcp_result_if
  import rwcp_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] format_offset;
  logic [31:0] data_offset;
  logic [31:0] data_size;

  modport source (output valid, output status, output format_offset, output data_offset,
                  output data_size, input ready);
  modport sink   (input valid, input status, input format_offset, input data_offset,
                  input data_size, output ready);
endinterface

interface rwcp_cfg_if
  import rwcp_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/riff_wave_chunk_parser_top.sv]
// Top level of the RIFF/WAVE chunk parser: byte-serial header and chunk walker.
//
// Usage: feed the file one byte per beat on the byte channel, with
// start_of_file high on byte 0. The parser checks the RIFF and WAVE tags,
// walks the chunk list up to RIFF length + 8, and reports the body offset
// of the "fmt " chunk plus body offset and size of the "data" chunk.
// Exactly one result beat leaves per file: found, a tag error, a format
// chunk that is too short, or end of list. Bytes after that are dropped
// until the next start flag. Configuration beats (want_format, want_data,
// min_format_bytes) are always taken; write them only while idle.
// Throughput: one byte per cycle. Each byte costs one position increment
// and one compare against the list end, all between the parse state
// registers and the result register.
// Latency: the result beat is valid the cycle after the byte that ends
// the parse. A single result register separates the sides; while it holds
// a beat the receiver has not taken, the byte channel stalls, and it
// resumes in the same cycle the receiver takes that beat.
// Reset: synchronous; the parser waits for a start flag, the result
// register empties and the configuration returns to 1, 1, 14.
module riff_wave_chunk_parser_top
  import rwcp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rwcp_byte_if.sink     bytes,
  rwcp_result_if.source results,
  rwcp_cfg_if.sink      cfg
);

  // Configuration registers
  logic       want_format;
  logic       want_data;
  logic [7:0] min_format_bytes;

  // Parse state
  phase_t      phase,               phase_next;
  logic        finished,            finished_next;
  logic [33:0] byte_position,       byte_position_next;
  logic [31:0] word_shift,          word_shift_next;
  logic [3:0]  hdr_count,           hdr_count_next;
  logic [31:0] riff_tag_word,       riff_tag_word_next;
  logic [32:0] riff_end,            riff_end_next;
  logic [31:0] chunk_tag,           chunk_tag_next;
  logic [32:0] skip_remaining,      skip_remaining_next;
  logic        format_found,        format_found_next;
  logic        data_found,          data_found_next;
  logic [31:0] saved_format_offset, saved_format_offset_next;
  logic [31:0] saved_data_offset,   saved_data_offset_next;
  logic [31:0] saved_data_size,     saved_data_size_next;

  // Result register
  logic        out_valid;
  status_t     out_status;
  logic [31:0] out_format_offset;
  logic [31:0] out_data_offset;
  logic [31:0] out_data_size;

  logic    accept;
  logic    emit;
  status_t emit_status;
  logic    chunk_closed;
  logic [31:0] word;

  // Take a byte whenever the result register is empty or draining
  assign bytes.ready = !out_valid || results.ready;
  assign accept      = bytes.valid && bytes.ready;
  assign cfg.ready   = 1'b1;

  assign word = {bytes.file_byte, word_shift[31:8]};

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      want_format      <= 1'b1;
      want_data        <= 1'b1;
      min_format_bytes <= MIN_FORMAT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_WANT_FORMAT:    want_format      <= cfg.data[0];
        CFG_WANT_DATA:      want_data        <= cfg.data[0];
        CFG_MIN_FORMAT_LEN: min_format_bytes <= cfg.data;
        default: ;
      endcase
    end
  end

  // Per-byte parse step. A start flag clears the parse state first, then the
  // byte is handled against the cleared values.
  always_comb begin
    phase_next               = phase;
    finished_next            = finished;
    byte_position_next       = byte_position;
    word_shift_next          = word_shift;
    hdr_count_next           = hdr_count;
    riff_tag_word_next       = riff_tag_word;
    riff_end_next            = riff_end;
    chunk_tag_next           = chunk_tag;
    skip_remaining_next      = skip_remaining;
    format_found_next        = format_found;
    data_found_next          = data_found;
    saved_format_offset_next = saved_format_offset;
    saved_data_offset_next   = saved_data_offset;
    saved_data_size_next     = saved_data_size;
    emit                     = 1'b0;
    emit_status              = ST_END;
    chunk_closed             = 1'b0;

    if (accept && bytes.start_of_file) begin
      phase_next               = PH_HEAD;
      finished_next            = 1'b0;
      byte_position_next       = '0;
      word_shift_next          = '0;
      hdr_count_next           = '0;
      format_found_next        = 1'b0;
      data_found_next          = 1'b0;
      saved_format_offset_next = '0;
      saved_data_offset_next   = '0;
      saved_data_size_next     = '0;
    end

    if (accept && !finished_next) begin
      byte_position_next = byte_position_next + 34'd1;

      if (phase_next == PH_SKIP) begin
        skip_remaining_next = skip_remaining_next - 33'd1;
        chunk_closed        = (skip_remaining_next == '0);
      end else begin
        word_shift_next = word;
        hdr_count_next  = hdr_count_next + 4'd1;

        if (phase_next == PH_HEAD) begin
          if (hdr_count_next == HDR_WORD0) begin
            riff_tag_word_next = word;
          end else if (hdr_count_next == HDR_WORD1) begin
            riff_end_next = {1'b0, word} + 33'd8;
          end else if (hdr_count_next == HDR_WORD2) begin
            // Form type is checked before the RIFF tag
            if (word != TAG_WAVE) begin
              emit        = 1'b1;
              emit_status = ST_NOT_WAVE;
            end else if (riff_tag_word_next != TAG_RIFF) begin
              emit        = 1'b1;
              emit_status = ST_NOT_RIFF;
            end else begin
              chunk_closed = 1'b1;
            end
          end
        end else begin
          if (hdr_count_next == HDR_WORD0) begin
            chunk_tag_next = word;
          end else if (hdr_count_next == HDR_WORD1) begin
            hdr_count_next = '0;
            if (chunk_tag_next == TAG_FMT && want_format && !format_found_next) begin
              if (word < {24'd0, min_format_bytes}) begin
                emit        = 1'b1;
                emit_status = ST_FMT_SHORT;
              end else begin
                saved_format_offset_next = byte_position_next[31:0];
                format_found_next        = 1'b1;
                if (!want_data || data_found_next) begin
                  emit        = 1'b1;
                  emit_status = ST_FOUND;
                end
              end
            end else if (chunk_tag_next == TAG_DATA && want_data && !data_found_next) begin
              saved_data_offset_next = byte_position_next[31:0];
              saved_data_size_next   = word;
              // An empty data chunk is recorded but does not set data_found; it can still end the parse as found
              data_found_next        = (word != '0);
              if (!want_format || format_found_next) begin
                emit        = 1'b1;
                emit_status = ST_FOUND;
              end
            end
            if (!emit) begin
              // Pad the body to an even length; it is empty only for length zero
              skip_remaining_next = ({1'b0, word} + 33'd1) & ~33'd1;
              if (word == '0) begin
                chunk_closed = 1'b1;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
        end
      end

      // Chunk boundary: stop at the list end, else read the next header
      if (chunk_closed) begin
        if (byte_position_next >= {1'b0, riff_end_next}) begin
          emit        = 1'b1;
          emit_status = ST_END;
        end else begin
          phase_next     = PH_CHUNK;
          hdr_count_next = '0;
        end
      end

      if (emit) begin
        finished_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      finished      <= 1'b1;
      byte_position <= '0;
      hdr_count     <= '0;
    end else begin
      phase         <= phase_next;
      finished      <= finished_next;
      byte_position <= byte_position_next;
      hdr_count     <= hdr_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_found <= 1'b0;
      data_found   <= 1'b0;
    end else begin
      format_found <= format_found_next;
      data_found   <= data_found_next;
    end
  end

  // Payload state; every field is written before it is read
  always_ff @(posedge clk) begin
    word_shift          <= word_shift_next;
    riff_tag_word       <= riff_tag_word_next;
    riff_end            <= riff_end_next;
    chunk_tag           <= chunk_tag_next;
    skip_remaining      <= skip_remaining_next;
    saved_format_offset <= saved_format_offset_next;
    saved_data_offset   <= saved_data_offset_next;
    saved_data_size     <= saved_data_size_next;
  end

  // Result register: load on emit, drop once the receiver takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status        <= emit_status;
      out_format_offset <= saved_format_offset_next;
      out_data_offset   <= saved_data_offset_next;
      out_data_size     <= saved_data_size_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.status        = out_status;
  assign results.format_offset = out_format_offset;
  assign results.data_offset   = out_data_offset;
  assign results.data_size     = out_data_size;

  // A result always closes the parse
  a_emit_finishes: assert property (@(posedge clk) disable iff (rst)
    emit |=> finished)
    else $error("result emitted without closing the parse");

  // Header byte count stays within the twelve-byte file header
  a_hdr_bound: assert property (@(posedge clk) disable iff (rst)
    hdr_count <= HDR_WORD2)
    else $error("header byte count out of range");

  // A chunk header never holds more than eight bytes
  a_chunk_hdr: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CHUNK) |-> (hdr_count < HDR_WORD1))
    else $error("chunk header count overran");

  // While skipping, a body byte is always still pending
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP && !finished) |-> (skip_remaining != '0))
    else $error("skip phase with nothing left to skip");

endmodule
